// ----- hw/rtl/triangle_face_normal_macros.svh -----
// assertion macros for the triangle face normal checker
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// clocked assertion, off while in reset
`define TFN_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("triangle face normal check failed");

// clocked assertion that also holds through reset
`define TFN_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("triangle face normal check failed");

`endif

// ----- hw/rtl/tfn_pkg.sv -----
// shared types and constants of the triangle face normal block
package tfn_pkg;

  localparam int unsigned NUM_AXES = 3;

  // control word that travels with each pipeline stage
  typedef struct packed {
    logic                valid;
    logic                degen;
    logic [NUM_AXES-1:0] neg;
  } tfn_ctl_t;

endpackage

// ----- hw/rtl/tfn_root_step.sv -----
// one bit of the normalizing root search, all three axes, registered
module tfn_root_step import tfn_pkg::*; #(
  parameter int unsigned W  = 134,
  parameter int unsigned YW = 16,
  parameter int unsigned K  = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tfn_ctl_t       ctl_i,
  input  logic [W-1:0]   s_i,
  input  logic [W-1:0]   r_i [NUM_AXES],
  input  logic [W-1:0]   q_i [NUM_AXES],
  input  logic [YW-1:0]  y_i [NUM_AXES],
  output tfn_ctl_t       ctl_o,
  output logic [W-1:0]   s_o,
  output logic [W-1:0]   r_o [NUM_AXES],
  output logic [W-1:0]   q_o [NUM_AXES],
  output logic [YW-1:0]  y_o [NUM_AXES]
);

  logic [W:0]    trial [NUM_AXES];
  logic          fit   [NUM_AXES];
  logic [W-1:0]  r_d   [NUM_AXES];
  logic [W-1:0]  q_d   [NUM_AXES];
  logic [YW-1:0] y_d   [NUM_AXES];

  // y^2*S grows by 2^(k+1)*y*S + 4^k*S when bit k is set
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      trial[i] = ({1'b0, q_i[i]} << (K + 1)) + ({1'b0, s_i} << (2 * K));
      fit[i]   = {1'b0, r_i[i]} >= trial[i];
      r_d[i]   = fit[i] ? (r_i[i] - trial[i][W-1:0]) : r_i[i];
      q_d[i]   = fit[i] ? (q_i[i] + (s_i << K)) : q_i[i];
      y_d[i]   = fit[i] ? (y_i[i] | (YW'(1) << K)) : y_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_o <= s_i;
    r_o <= r_d;
    q_o <= q_d;
    y_o <= y_d;
  end

endmodule

// ----- hw/rtl/triangle_face_normal.sv -----
// triangle face normal: edge cross product scaled to a unit vector
// One triangle word is taken in every clock cycle (busy_o stays low) and its
// normal comes out at the end of the pipeline, for one cycle, marked
// by done_o; the receiver has no way to hold it back, so it must take every
// word. The pipeline has six front stages (edges, edge products, cross
// product magnitude and sign, squaring partial products, squares, sum of
// squares) then one stage per output bit of an exact restoring root search
// (NORMAL_FRAC_BITS + 2 stages) and one rounding stage. Most stages belong to
// that bit-serial search; throughput is one word per cycle. Each component is
// n_i * 2^F / |n| rounded to nearest, ties away from zero, in signed
// Q1.F. A triangle whose cross product is zero gives a zero normal with
// degenerate_o set.
module triangle_face_normal import tfn_pkg::*; #(
  parameter int unsigned COORD_BITS       = 24,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [COORD_BITS-1:0]       a_x_i,
  input  logic signed [COORD_BITS-1:0]       a_y_i,
  input  logic signed [COORD_BITS-1:0]       a_z_i,
  input  logic signed [COORD_BITS-1:0]       b_x_i,
  input  logic signed [COORD_BITS-1:0]       b_y_i,
  input  logic signed [COORD_BITS-1:0]       b_z_i,
  input  logic signed [COORD_BITS-1:0]       c_x_i,
  input  logic signed [COORD_BITS-1:0]       c_y_i,
  input  logic signed [COORD_BITS-1:0]       c_z_i,
  output logic                               done_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] norm_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] norm_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] norm_z_o,
  output logic                               degenerate_o
);

  // widths
  localparam int unsigned EW    = COORD_BITS + 1;      // edge
  localparam int unsigned PW    = 2 * EW;              // edge product
  localparam int unsigned NW    = PW + 1;              // signed cross component
  localparam int unsigned MW    = 2 * COORD_BITS + 2;  // cross magnitude
  localparam int unsigned HW    = MW / 2;              // low half of magnitude
  localparam int unsigned GW    = MW - HW;             // high half of magnitude
  localparam int unsigned SQW   = 2 * MW;              // square of magnitude
  localparam int unsigned W     = 2 * MW + 2 * NORMAL_FRAC_BITS + 4; // root datapath
  localparam int unsigned YW    = NORMAL_FRAC_BITS + 2; // doubled quotient
  localparam int unsigned OW    = NORMAL_FRAC_BITS + 2; // output component
  localparam int unsigned NSTEP = YW;

  // always ready: one word per cycle, no stall
  assign busy_o = 1'b0;

  // input gathering
  logic signed [COORD_BITS-1:0] a_v [NUM_AXES];
  logic signed [COORD_BITS-1:0] b_v [NUM_AXES];
  logic signed [COORD_BITS-1:0] c_v [NUM_AXES];

  assign a_v[0] = a_x_i;
  assign a_v[1] = a_y_i;
  assign a_v[2] = a_z_i;
  assign b_v[0] = b_x_i;
  assign b_v[1] = b_y_i;
  assign b_v[2] = b_z_i;
  assign c_v[0] = c_x_i;
  assign c_v[1] = c_y_i;
  assign c_v[2] = c_z_i;

  // stage 1: edge vectors from the first vertex
  tfn_ctl_t            ctl1_q;
  logic signed [EW-1:0] e1_q [NUM_AXES];
  logic signed [EW-1:0] e2_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      e1_q[i] <= EW'(b_v[i]) - EW'(a_v[i]);
      e2_q[i] <= EW'(c_v[i]) - EW'(a_v[i]);
    end
  end

  // stage 2: the edge products of the cross product, a pair per component
  tfn_ctl_t             ctl2_q;
  logic signed [PW-1:0] p_q [NUM_AXES];
  logic signed [PW-1:0] m_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    p_q[0] <= e1_q[1] * e2_q[2];
    m_q[0] <= e1_q[2] * e2_q[1];
    p_q[1] <= e1_q[2] * e2_q[0];
    m_q[1] <= e1_q[0] * e2_q[2];
    p_q[2] <= e1_q[0] * e2_q[1];
    m_q[2] <= e1_q[1] * e2_q[0];
  end

  // stage 3: cross components as sign and magnitude
  tfn_ctl_t             ctl3_d;
  tfn_ctl_t             ctl3_q;
  logic signed [NW-1:0] n_d   [NUM_AXES];
  logic [NW-1:0]        abs_d [NUM_AXES];
  logic [MW-1:0]        mag_q [NUM_AXES];

  always_comb begin
    ctl3_d = ctl2_q;
    for (int i = 0; i < NUM_AXES; i++) begin
      n_d[i]        = NW'(p_q[i]) - NW'(m_q[i]);
      ctl3_d.neg[i] = n_d[i][NW-1];
      abs_d[i]      = n_d[i][NW-1] ? (-n_d[i]) : n_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mag_q[i] <= abs_d[i][MW-1:0];
    end
  end

  // stage 4: partial products of the square, split into halves
  tfn_ctl_t          ctl4_q;
  logic [2*HW-1:0]   ll_q [NUM_AXES];
  logic [HW+GW-1:0]  lh_q [NUM_AXES];
  logic [2*GW-1:0]   hh_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      ll_q[i] <= mag_q[i][HW-1:0] * mag_q[i][HW-1:0];
      lh_q[i] <= mag_q[i][MW-1:HW] * mag_q[i][HW-1:0];
      hh_q[i] <= mag_q[i][MW-1:HW] * mag_q[i][MW-1:HW];
    end
  end

  // stage 5: squares of the cross components
  tfn_ctl_t       ctl5_q;
  logic [SQW-1:0] sq_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sq_q[i] <= (SQW'(hh_q[i]) << (2 * HW)) + (SQW'(lh_q[i]) << (HW + 1))
               + SQW'(ll_q[i]);
    end
  end

  // stage 6: squared length, remainders seeded with n_i^2 * 2^(2F+2)
  tfn_ctl_t      ctl_s [NSTEP+1];
  tfn_ctl_t      ctl6_d;
  logic [W-1:0]  sum_d;
  logic [W-1:0]  s_s   [NSTEP+1];
  logic [W-1:0]  r_s   [NSTEP+1][NUM_AXES];
  logic [W-1:0]  q_s   [NSTEP+1][NUM_AXES];
  logic [YW-1:0] y_s   [NSTEP+1][NUM_AXES];

  always_comb begin
    sum_d        = W'(sq_q[0]) + W'(sq_q[1]) + W'(sq_q[2]);
    ctl6_d       = ctl5_q;
    ctl6_d.degen = (sum_d == '0);
  end

  always_ff @(posedge clk_i) begin
    s_s[0] <= sum_d;
    for (int i = 0; i < NUM_AXES; i++) begin
      r_s[0][i] <= W'(sq_q[i]) << (2 * NORMAL_FRAC_BITS + 2);
      q_s[0][i] <= '0;
      y_s[0][i] <= '0;
    end
  end

  // control pipeline for the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q   <= '0;
      ctl2_q   <= '0;
      ctl3_q   <= '0;
      ctl4_q   <= '0;
      ctl5_q   <= '0;
      ctl_s[0] <= '0;
    end else begin
      ctl1_q   <= '{valid: start_i & ~busy_o, degen: 1'b0, neg: '0};
      ctl2_q   <= ctl1_q;
      ctl3_q   <= ctl3_d;
      ctl4_q   <= ctl3_q;
      ctl5_q   <= ctl4_q;
      ctl_s[0] <= ctl6_d;
    end
  end

  // root search: y = floor(2^(F+1) * |n_i| / |n|), one bit per stage, msb first
  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    tfn_root_step #(
      .W  (W),
      .YW (YW),
      .K  (NSTEP - 1 - g)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[g]),
      .s_i    (s_s[g]),
      .r_i    (r_s[g]),
      .q_i    (q_s[g]),
      .y_i    (y_s[g]),
      .ctl_o  (ctl_s[g+1]),
      .s_o    (s_s[g+1]),
      .r_o    (r_s[g+1]),
      .q_o    (q_s[g+1]),
      .y_o    (y_s[g+1])
    );
  end

  // output stage: round half away from zero, apply sign
  logic [YW:0]   half_d [NUM_AXES];
  logic [OW-1:0] comp_d [NUM_AXES];
  logic [OW-1:0] comp_q [NUM_AXES];
  logic          done_q;
  logic          degen_q;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      half_d[i] = ({1'b0, y_s[NSTEP][i]} + (YW+1)'(1)) >> 1;
      if (ctl_s[NSTEP].degen) begin
        comp_d[i] = '0;
      end else if (ctl_s[NSTEP].neg[i]) begin
        comp_d[i] = -half_d[i][OW-1:0];
      end else begin
        comp_d[i] = half_d[i][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_s[NSTEP].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    comp_q  <= comp_d;
    degen_q <= ctl_s[NSTEP].degen;
  end

  assign done_o       = done_q;
  assign norm_x_o     = comp_q[0];
  assign norm_y_o     = comp_q[1];
  assign norm_z_o     = comp_q[2];
  assign degenerate_o = degen_q;

endmodule

// ----- hw/rtl/tfn_checker.sv -----
// port level checks of the triangle face normal block, bound to the top level
`include "triangle_face_normal_macros.svh"

module tfn_checker #(
  parameter int unsigned COORD_BITS       = 24,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic                               done_o,
  input logic signed [NORMAL_FRAC_BITS+1:0] norm_x_o,
  input logic signed [NORMAL_FRAC_BITS+1:0] norm_y_o,
  input logic signed [NORMAL_FRAC_BITS+1:0] norm_z_o,
  input logic                               degenerate_o
);

  localparam int unsigned LAT = NORMAL_FRAC_BITS + 9;
  localparam int ONE = 2 ** NORMAL_FRAC_BITS;

  // every word out was taken in earlier, while the block was not busy
  `TFN_ASSERT(a_done_has_start, done_o |-> $past(start_i && !busy_o, LAT))

  // the pipeline never pushes back
  `TFN_ASSERT_ALWAYS(a_never_busy, !busy_o)

  // a degenerate triangle gives a zero normal
  `TFN_ASSERT(a_degen_zero,
    done_o && degenerate_o |-> norm_x_o == 0 && norm_y_o == 0 && norm_z_o == 0)

  // a real normal is not the zero vector
  `TFN_ASSERT(a_normal_nonzero,
    done_o && !degenerate_o |-> norm_x_o != 0 || norm_y_o != 0 || norm_z_o != 0)

  // components stay within plus and minus one
  `TFN_ASSERT(a_normal_range,
    done_o |-> norm_x_o <= ONE && norm_x_o >= -ONE && norm_y_o <= ONE &&
               norm_y_o >= -ONE && norm_z_o <= ONE && norm_z_o >= -ONE)

endmodule

bind triangle_face_normal tfn_checker #(
  .COORD_BITS       (COORD_BITS),
  .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tfn_checker (.*);
